// ----- hw/rtl/ts_packet_pid_demux_assert.svh -----
// Assertion macros shared by the demux RTL.
`ifndef TS_PACKET_PID_DEMUX_ASSERT_SVH
`define TS_PACKET_PID_DEMUX_ASSERT_SVH

// same-cycle implication
`define TSPD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/tspd_pkg.sv -----
`timescale 1ns / 1ps

package tspd_pkg;

  localparam int NUM_FILTER_SLOTS = 4;
  localparam int SLOT_W           = 2;
  localparam int CFG_IDX_W        = $clog2(NUM_FILTER_SLOTS);
  localparam int FLT_W            = 15;
  localparam int FLT_PID_W        = 13;
  localparam int FLT_EN_BIT       = 13;
  localparam int FLT_RAW_BIT      = 14;

  localparam logic [7:0]           TS_SYNC   = 8'h47;
  localparam logic [FLT_PID_W-1:0] NULL_PID  = 13'h1FFF;
  localparam int                   PKT_BYTES = 188;
  localparam int                   HDR_BYTES = 4;

  localparam logic [7:0] POS_LAST     = 8'(PKT_BYTES - 1);
  localparam logic [7:0] POS_HDR_LAST = 8'(HDR_BYTES - 1);
  localparam logic [7:0] POS_AF_LEN   = 8'(HDR_BYTES);
  localparam logic [7:0] HEAD_OFFSET  = 8'(HDR_BYTES);

  localparam int HDR1_TEI  = 7;
  localparam int HDR1_PUSI = 6;
  localparam int HDR3_AF   = 5;
  localparam int HDR3_PAY  = 4;

  localparam int MAX_RESULTS = 4;
  localparam int PUSH_CNT_W  = $clog2(MAX_RESULTS + 1);
  localparam int OQ_DEPTH    = 8;
  localparam int OQ_IDX_W    = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [7:0]        data;
    logic [SLOT_W-1:0] slot;
    logic              ustart;
    logic              cbegin;
    logic              cend;
  } res_t;

  typedef struct packed {
    logic [PUSH_CNT_W-1:0]        count;
    res_t [MAX_RESULTS-1:0]       item;
  } push_t;

endpackage

// ----- hw/rtl/tspd_res_fifo.sv -----
`timescale 1ns / 1ps

module tspd_res_fifo import tspd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  head
);

  res_t                mem [OQ_DEPTH];
  logic [OQ_IDX_W-1:0] wr_ptr;
  logic [OQ_IDX_W-1:0] rd_ptr;
  logic [OQ_CNT_W-1:0] count;
  logic                pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign room      = (count <= OQ_CNT_W'(OQ_DEPTH - MAX_RESULTS));
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_IDX_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_IDX_W'(1);
      end
      count <= count + OQ_CNT_W'(push.count) - OQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_RESULTS; j++) begin
      if (PUSH_CNT_W'(j) < push.count) begin
        mem[wr_ptr + OQ_IDX_W'(j)] <= push.item[j];
      end
    end
  end

endmodule

// ----- hw/rtl/ts_packet_pid_demux.sv -----
`timescale 1ns / 1ps
// Transport stream PID demultiplexer. Takes one stream byte per cycle on the
// input channel, hunts for the sync byte, frames 188-byte packets and forwards
// the bytes of packets whose PID matches an enabled filter slot (lowest slot
// wins), either as whole raw packets or as section/PES payload with the
// adaptation field removed and the pointer field applied. A byte taken in is
// held in an input register until the result queue has room, then processed,
// and its results are written to the output queue at the end of that cycle.
// A byte gives up to four results in one cycle (the raw header burst, the held
// PES prefix); an eight-entry result queue drains one result per cycle while
// out_ready is high, and the input keeps taking one byte per cycle as long as
// the queue holds four entries or fewer. The user must write filter slots
// through the configuration port only while no packet is in flight; the
// block itself does not enforce it.

`include "ts_packet_pid_demux_assert.svh"

module ts_packet_pid_demux import tspd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FLT_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           payload_byte,
  output logic [SLOT_W-1:0]    filter_slot,
  output logic                 unit_start,
  output logic                 chunk_begin,
  output logic                 chunk_end
);

  typedef enum logic [2:0] {
    MODE_DROP,
    MODE_RAW,
    MODE_CONT,
    MODE_PES,
    MODE_LOOK,
    MODE_SECT,
    MODE_AFWAIT
  } mode_t;

  logic [FLT_W-1:0]  flt [NUM_FILTER_SLOTS];
  logic              in_full;
  logic [7:0]        in_byte;
  logic [7:0]        pos, pos_next;
  logic [7:0]        hdr1, hdr1_next;
  logic [7:0]        hdr2, hdr2_next;
  logic [7:0]        hdr3, hdr3_next;
  logic [SLOT_W-1:0] slot, slot_next;
  mode_t             mode, mode_next;
  logic [7:0]        off, off_next;
  logic [7:0]        look [3];
  logic [7:0]        look_next [3];
  logic [7:0]        look_wr [3];
  logic [1:0]        look_cnt, look_cnt_next;
  logic [1:0]        cnt_inc;
  logic [7:0]        ptr, ptr_next;

  logic                 fire;
  logic                 oq_room;
  logic                 last;
  logic                 pusi;
  logic [FLT_PID_W-1:0] pid;
  logic                 hit;
  logic [SLOT_W-1:0]    hit_idx;
  logic                 hit_raw;
  logic [8:0]           af_off;
  logic [7:0]           rest;
  logic [7:0]           ptr_val;
  logic                 pes_hit;
  push_t                step;
  push_t                oq_push;
  res_t                 head;

  function automatic res_t mk_res(input logic [7:0] d, input logic us, input logic b,
                                  input logic e);
    res_t r;
    r.data   = d;
    r.slot   = '0;
    r.ustart = us;
    r.cbegin = b;
    r.cend   = e;
    return r;
  endfunction

  // byte k after the pointer field; the pointer splits old tail from new unit
  function automatic res_t sect_res(input logic [7:0] k, input logic [7:0] p,
                                    input logic [7:0] d, input logic lst);
    res_t r;
    if (k < p) begin
      r = mk_res(d, 1'b0, (k == '0), ((k + 8'd1) == p));
    end else begin
      r = mk_res(d, 1'b1, (k == p), lst);
    end
    return r;
  endfunction

  assign fire     = in_full && oq_room;
  assign in_ready = !in_full || fire;
  assign last     = (pos == POS_LAST);
  assign pusi     = hdr1[HDR1_PUSI];
  assign pid      = {hdr1[4:0], hdr2};

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    hit_raw = 1'b0;
    for (int i = NUM_FILTER_SLOTS - 1; i >= 0; i--) begin
      if (flt[i][FLT_EN_BIT] && (flt[i][FLT_PID_W-1:0] == pid)) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
        hit_raw = flt[i][FLT_RAW_BIT];
      end
    end
  end

  always_comb begin
    pos_next      = pos;
    hdr1_next     = hdr1;
    hdr2_next     = hdr2;
    hdr3_next     = hdr3;
    slot_next     = slot;
    mode_next     = mode;
    off_next      = off;
    look_next     = look;
    look_cnt_next = look_cnt;
    ptr_next      = ptr;
    step          = '0;

    look_wr           = look;
    look_wr[look_cnt] = in_byte;
    cnt_inc           = look_cnt + 2'd1;
    af_off            = 9'(HDR_BYTES + 1) + {1'b0, in_byte};
    rest              = POS_LAST - off;
    ptr_val           = look_wr[0];
    pes_hit           = (cnt_inc == 2'd3) && (look_wr[0] == 8'h00) &&
                        (look_wr[1] == 8'h00) && (look_wr[2] == 8'h01);

    if (pos == '0) begin
      if (in_byte == TS_SYNC) begin
        pos_next      = 8'd1;
        mode_next     = MODE_DROP;
        off_next      = '0;
        look_cnt_next = '0;
        ptr_next      = '0;
      end
    end else begin
      pos_next = last ? '0 : pos + 8'd1;
      if (pos == 8'd1) begin
        hdr1_next = in_byte;
      end else if (pos == 8'd2) begin
        hdr2_next = in_byte;
      end else if (pos == POS_HDR_LAST) begin
        hdr3_next = in_byte;
        mode_next = MODE_DROP;
        if (!hdr1[HDR1_TEI] && (pid != NULL_PID) && hit) begin
          slot_next = hit_idx;
          if (hit_raw) begin
            mode_next    = MODE_RAW;
            step.count   = PUSH_CNT_W'(4);
            step.item[0] = mk_res(TS_SYNC, pusi, 1'b1, 1'b0);
            step.item[1] = mk_res(hdr1, pusi, 1'b0, 1'b0);
            step.item[2] = mk_res(hdr2, pusi, 1'b0, 1'b0);
            step.item[3] = mk_res(in_byte, pusi, 1'b0, 1'b0);
          end else if (in_byte[HDR3_AF]) begin
            mode_next = MODE_AFWAIT;
          end else if (in_byte[HDR3_PAY]) begin
            off_next  = HEAD_OFFSET;
            mode_next = pusi ? MODE_LOOK : MODE_CONT;
          end
        end
      end else if ((pos == POS_AF_LEN) && (mode == MODE_AFWAIT)) begin
        if (hdr3[HDR3_PAY] && (af_off < 9'(PKT_BYTES))) begin
          off_next  = af_off[7:0];
          mode_next = pusi ? MODE_LOOK : MODE_CONT;
        end else begin
          mode_next = MODE_DROP;
        end
      end else begin
        case (mode)
          MODE_RAW: begin
            step.count   = PUSH_CNT_W'(1);
            step.item[0] = mk_res(in_byte, pusi, 1'b0, last);
          end
          MODE_CONT, MODE_PES: begin
            if (pos >= off) begin
              step.count   = PUSH_CNT_W'(1);
              step.item[0] = mk_res(in_byte, (mode == MODE_PES), (pos == off), last);
            end
          end
          MODE_LOOK: begin
            if (pos >= off) begin
              look_next     = look_wr;
              look_cnt_next = cnt_inc;
              if ((cnt_inc == 2'd3) || last) begin
                if (pes_hit) begin
                  mode_next    = MODE_PES;
                  step.count   = PUSH_CNT_W'(3);
                  step.item[0] = mk_res(8'h00, 1'b1, 1'b1, 1'b0);
                  step.item[1] = mk_res(8'h00, 1'b1, 1'b0, 1'b0);
                  step.item[2] = mk_res(8'h01, 1'b1, 1'b0, last);
                end else if ((ptr_val != '0) && (ptr_val >= rest)) begin
                  mode_next = MODE_DROP;
                end else begin
                  mode_next    = MODE_SECT;
                  ptr_next     = ptr_val;
                  step.count   = PUSH_CNT_W'(cnt_inc) - PUSH_CNT_W'(1);
                  step.item[0] = sect_res(8'd0, ptr_val, look_wr[1],
                                          ((off + 8'd1) == POS_LAST));
                  step.item[1] = sect_res(8'd1, ptr_val, look_wr[2],
                                          ((off + 8'd2) == POS_LAST));
                end
              end
            end
          end
          MODE_SECT: begin
            if (pos > off) begin
              step.count   = PUSH_CNT_W'(1);
              step.item[0] = sect_res(pos - off - 8'd1, ptr, in_byte, last);
            end
          end
          default: begin
          end
        endcase
      end
    end

    for (int j = 0; j < MAX_RESULTS; j++) begin
      step.item[j].slot = slot_next;
    end
  end

  always_comb begin
    oq_push       = step;
    oq_push.count = fire ? step.count : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FILTER_SLOTS; i++) begin
        flt[i] <= '0;
      end
      in_full  <= 1'b0;
      pos      <= '0;
      hdr1     <= '0;
      hdr2     <= '0;
      hdr3     <= '0;
      slot     <= '0;
      mode     <= MODE_DROP;
      off      <= '0;
      look     <= '{default: '0};
      look_cnt <= '0;
      ptr      <= '0;
    end else begin
      if (cfg_we) begin
        flt[cfg_index] <= cfg_data;
      end
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
        in_byte <= data_byte;
      end else if (fire) begin
        in_full <= 1'b0;
      end
      if (fire) begin
        pos      <= pos_next;
        hdr1     <= hdr1_next;
        hdr2     <= hdr2_next;
        hdr3     <= hdr3_next;
        slot     <= slot_next;
        mode     <= mode_next;
        off      <= off_next;
        look     <= look_next;
        look_cnt <= look_cnt_next;
        ptr      <= ptr_next;
      end
    end
  end

  tspd_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (oq_push),
    .room      (oq_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign payload_byte = head.data;
  assign filter_slot  = head.slot;
  assign unit_start   = head.ustart;
  assign chunk_begin  = head.cbegin;
  assign chunk_end    = head.cend;

  `TSPD_ASSERT_IMPL(a_hunt_silent, pos == '0, step.count == '0, "result while hunting")
  `TSPD_ASSERT_NEXT(a_pos_wrap, fire && last, pos == '0, "packet did not end at last byte")
  `TSPD_ASSERT_IMPL(a_burst_src, step.count > PUSH_CNT_W'(2), pos == POS_HDR_LAST || mode == MODE_LOOK, "unexpected burst")
  `TSPD_ASSERT_IMPL(a_room_on_push, oq_push.count != '0, oq_room, "push without queue room")

endmodule
